/* sv/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk_i edge, off while rst_ni is low.
`define P2B_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication variant: antecedent in the same cycle.
`define P2B_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* sv/p2b_pkg.sv */
package p2b_pkg;

  typedef enum logic [1:0] {
    FMT_BGRA8 = 2'd0,
    FMT_RGBA8 = 2'd1,
    FMT_HALF  = 2'd2
  } p2b_fmt_e;

  localparam int unsigned NUM_LANES = 4;

  // binary16 fields
  localparam logic [4:0]  EXP_MAX    = 5'd31;
  localparam logic [4:0]  EXP_ONE    = 5'd15;
  localparam logic [4:0]  EXP_DENORM = 5'd0;
  localparam logic [7:0]  UNORM_MAX  = 8'd255;
  localparam logic [31:0] ROUND_HALF = 32'h0080_0000;

  typedef struct packed {
    logic [15:0] src_lane3;
    logic [15:0] src_lane2;
    logic [15:0] src_lane1;
    logic [15:0] src_lane0;
  } p2b_in_t;

  typedef struct packed {
    logic [7:0] alpha_byte;
    logic [7:0] red_byte;
    logic [7:0] green_byte;
    logic [7:0] blue_byte;
  } p2b_out_t;

  // Control carried alongside the lane registers.
  typedef struct packed {
    logic valid;
    logic swap;
  } p2b_stage_t;

endpackage

/* sv/p2b_lane.sv */
module p2b_lane (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic        half_i,
  input  logic [15:0] data_i,
  output logic [7:0]  byte_o
);
  import p2b_pkg::*;

  logic        sign;
  logic [4:0]  ex;
  logic [9:0]  mant;
  logic [10:0] sig;
  logic        force_d, force_q;
  logic [7:0]  val_d, val_q;
  logic [18:0] prod_d, prod_q;
  logic [3:0]  sh_d, sh_q;
  logic [31:0] scaled;

  assign sign = data_i[15];
  assign ex   = data_i[14:10];
  assign mant = data_i[9:0];

  always_comb begin
    force_d = 1'b1;
    val_d   = 8'd0;
    if (!half_i) begin
      val_d = data_i[7:0];
    end else if (ex == EXP_MAX) begin
      // +inf saturates, NaN and -inf go to zero
      val_d = ((mant == 10'd0) && !sign) ? UNORM_MAX : 8'd0;
    end else if (sign) begin
      val_d = 8'd0;
    end else if (ex >= EXP_ONE) begin
      val_d = UNORM_MAX;
    end else begin
      force_d = 1'b0;
    end
  end

  // h = sig * 2^(e-1) * 2^-24, denormals use e = 1
  assign sig    = (ex == EXP_DENORM) ? {1'b0, mant} : {1'b1, mant};
  assign sh_d   = (ex == EXP_DENORM) ? 4'd0 : (ex[3:0] - 4'd1);
  assign prod_d = 19'(sig) * 19'(UNORM_MAX);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      force_q <= force_d;
      val_q   <= val_d;
      prod_q  <= prod_d;
      sh_q    <= sh_d;
    end
  end

  assign scaled = (32'(prod_q) << sh_q) + ROUND_HALF;
  assign byte_o = force_q ? val_q : scaled[31:24];

endmodule

/* sv/p2b_merge.sv */
module p2b_merge (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  p2b_pkg::p2b_stage_t                ctrl_i,
  input  logic [p2b_pkg::NUM_LANES-1:0][7:0] lane_i,
  input  logic                               out_ready_i,
  output logic                               adv_o,
  output logic                               out_valid_o,
  output p2b_pkg::p2b_out_t                  out_data_o
);
  import p2b_pkg::*;

  logic     valid_q;
  p2b_out_t data_d, data_q;

  // Lanes are in memory order; ctrl_i.swap (RGBA8, half) swaps first and third.
  always_comb begin
    data_d.green_byte = lane_i[1];
    data_d.alpha_byte = lane_i[3];
    if (ctrl_i.swap) begin
      data_d.blue_byte = lane_i[2];
      data_d.red_byte  = lane_i[0];
    end else begin
      data_d.blue_byte = lane_i[0];
      data_d.red_byte  = lane_i[2];
    end
  end

  assign adv_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_o) begin
      valid_q <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && ctrl_i.valid) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

/* sv/pixel_to_bgra8_converter_unit.sv */
// An input transaction passes the lane register, then the output register, to output valid.
// Throughput: 1 pixel per cycle unless output stalls; four channel lanes work in parallel.
// A stalled output holds the pipe; in_ready_o drops only when both stages are full
// and out_ready_i is low.
// Reset (rst_ni, async, active low): pipe emptied, source format back to BGRA8.
// Config transactions are always accepted; write only while the pipe is empty.
module pixel_to_bgra8_converter_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration write channel
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_data_i,
  // source pixel channel
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  p2b_pkg::p2b_in_t  in_data_i,
  // BGRA8 pixel channel
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output p2b_pkg::p2b_out_t out_data_o
);
  import p2b_pkg::*;

  logic [1:0]                  fmt_q;
  logic                        half_fmt;
  logic                        s1_en;
  logic                        s2_en;
  p2b_stage_t                  ctrl_d, ctrl_q;
  logic [NUM_LANES-1:0][15:0]  lane_in;
  logic [NUM_LANES-1:0][7:0]   lane_byte;

  // Format register; code 3 falls through to passthrough.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FMT_BGRA8;
    end else if (cfg_valid_i && cfg_ready_o) begin
      fmt_q <= cfg_data_i;
    end
  end

  assign half_fmt = (fmt_q == FMT_HALF);

  // Stage 1 loads when it is empty or the output stage takes its contents.
  assign s1_en      = !ctrl_q.valid || s2_en;
  assign in_ready_o = s1_en;

  assign ctrl_d.valid = in_valid_i;
  assign ctrl_d.swap  = (fmt_q == FMT_RGBA8) || (fmt_q == FMT_HALF);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (s1_en) begin
      ctrl_q <= ctrl_d;
    end
  end

  assign lane_in[0] = in_data_i.src_lane0;
  assign lane_in[1] = in_data_i.src_lane1;
  assign lane_in[2] = in_data_i.src_lane2;
  assign lane_in[3] = in_data_i.src_lane3;

  // One converter per channel: half decode + scale by 255, or low-byte pass.
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    p2b_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (s1_en && in_valid_i),
      .half_i (half_fmt),
      .data_i (lane_in[g]),
      .byte_o (lane_byte[g])
    );
  end

  // Swizzle into BGRA order and hold in the output register.
  p2b_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl_q),
    .lane_i      (lane_byte),
    .out_ready_i (out_ready_i),
    .adv_o       (s2_en),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

/* sv/p2b_checker.sv */
`include "assert_macros.svh"

module p2b_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              cfg_valid_i,
  input logic              cfg_ready_o,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input p2b_pkg::p2b_out_t out_data_o
);
  import p2b_pkg::*;

  logic in_xact;
  logic out_stall;

  assign in_xact   = in_valid_i && in_ready_o;
  assign out_stall = out_valid_o && !out_ready_i;

  // Output transaction stays offered, payload unchanged, until taken.
  `P2B_ASSERT_IMP(a_out_hold, $past(out_stall), out_valid_o, "output dropped while stalled")
  `P2B_ASSERT_IMP(a_out_stable, $past(out_stall), $stable(out_data_o), "payload changed")

  // Input stalls only when both stages are full and the sink stalls.
  `P2B_ASSERT_IMP(a_in_stall, !in_ready_o, out_stall, "input stalled without backpressure")

  // Config port never stalls.
  `P2B_ASSERT(a_cfg_ready, cfg_ready_o, "config port not ready")

  // No output appears without an input transaction feeding it.
  `P2B_ASSERT_IMP(a_no_spur, !$past(out_valid_o) && !$past(in_xact, 2), !out_valid_o, "no input")

endmodule

bind pixel_to_bgra8_converter_unit p2b_checker u_p2b_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

/* tb/testbench.sv */
module testbench;
  import p2b_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 4;   // pipe is two stages deep
  localparam int LONG_HOLD = 60;     // one long receiver stall to fill the pipe

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_data = 2'd0;

  logic in_valid = 1'b0;
  logic in_ready;
  p2b_in_t in_data = '0;

  logic out_valid;
  logic out_ready = 1'b0;
  p2b_out_t out_data;

  // Pixels waiting to be sent, and BGRA8 bytes owed by the block.
  p2b_in_t src_pixels[$];
  p2b_out_t bgra_expected[$];

  logic [1:0] cur_fmt = FMT_BGRA8;  // the block's format register as we believe it
  bit idle_on = 1'b0;
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;
  int errors = 0;
  int cycles = 0;
  int tx_gap = 0;
  int rx_stall = 0;
  bit tx_holding;
  p2b_out_t want;
  string byte_name[4] = '{"blue_byte", "green_byte", "red_byte", "alpha_byte"};

  pixel_to_bgra8_converter_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always #5 clk = ~clk;

  // binary16 -> unorm8: clamp to [0,1], floor(h*255 + 0.5), done in integers.
  function automatic logic [7:0] half_to_byte(logic [15:0] h);
    logic sgn;
    logic [4:0] ex;
    logic [9:0] man;
    logic [31:0] sig;
    logic [31:0] scaled;
    sgn = h[15];
    ex = h[14:10];
    man = h[9:0];
    // infinities and NaN first: only +inf saturates high
    if (ex == EXP_MAX) return (man == 10'd0 && !sgn) ? UNORM_MAX : 8'd0;
    if (sgn) return 8'd0;
    if (ex >= EXP_ONE) return UNORM_MAX;
    if (ex == EXP_DENORM) begin
      sig = {22'd0, man};
      ex = 5'd1;
    end else begin
      sig = {21'd0, 1'b1, man};
    end
    scaled = (sig * 32'd255) << (ex - 5'd1);
    return 8'((scaled + ROUND_HALF) >> 24);
  endfunction

  function automatic p2b_out_t predict_bgra(logic [1:0] fmt, p2b_in_t px);
    p2b_out_t o;
    if (fmt == FMT_HALF) begin
      o.blue_byte  = half_to_byte(px.src_lane2);
      o.green_byte = half_to_byte(px.src_lane1);
      o.red_byte   = half_to_byte(px.src_lane0);
      o.alpha_byte = half_to_byte(px.src_lane3);
    end else if (fmt == FMT_RGBA8) begin
      o.blue_byte  = px.src_lane2[7:0];
      o.green_byte = px.src_lane1[7:0];
      o.red_byte   = px.src_lane0[7:0];
      o.alpha_byte = px.src_lane3[7:0];
    end else begin
      // BGRA8, and the unused code 3 behaves the same
      o.blue_byte  = px.src_lane0[7:0];
      o.green_byte = px.src_lane1[7:0];
      o.red_byte   = px.src_lane2[7:0];
      o.alpha_byte = px.src_lane3[7:0];
    end
    return o;
  endfunction

  // Half lane biased toward the interesting ranges.
  function automatic logic [15:0] rand_half();
    case ($urandom_range(0, 9))
      0, 1:       return 16'($urandom);
      2, 3, 4, 5: return {1'b0, 5'($urandom_range(1, 14)), 10'($urandom)};
      6:          return {1'b0, 5'd0, 10'($urandom)};
      7:          return {1'b0, 5'($urandom_range(15, 30)), 10'($urandom)};
      8:          return {1'($urandom), 5'd31, ($urandom_range(0, 1) ? 10'd0 : 10'($urandom))};
      default:    return {1'b1, 15'($urandom)};
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  task automatic push_px(logic [15:0] l0, logic [15:0] l1, logic [15:0] l2, logic [15:0] l3);
    p2b_in_t px;
    px.src_lane0 = l0;
    px.src_lane1 = l1;
    px.src_lane2 = l2;
    px.src_lane3 = l3;
    src_pixels.insert(src_pixels.size(), px);
  endtask

  // Sender queue empty, nothing on the wire, nothing owed, then let the pipe settle.
  task automatic wait_drained();
    do @(posedge clk);
    while (src_pixels.size() != 0 || in_valid || bgra_expected.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_format(logic [1:0] fmt);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= fmt;
    do @(posedge clk);
    while (!cfg_ready);
    cur_fmt = fmt;
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(logic [1:0] fmt, int n, bit idle);
    wait_drained();
    write_format(fmt);
    idle_on = idle;
    for (int i = 0; i < n; i++) begin
      if (fmt == FMT_HALF)
        push_px(rand_half(), rand_half(), rand_half(), rand_half());
      else
        push_px(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  // Driver: holds each pixel until its transaction, random gaps between pixels while idle_on.
  always @(posedge clk) begin
    if (rst_n) begin
      tx_holding = in_valid;
      if (in_valid && in_ready) begin
        bgra_expected.insert(bgra_expected.size(), predict_bgra(cur_fmt, in_data));
        tx_holding = 1'b0;
      end
      if (!tx_holding) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
          tx_gap = $urandom_range(1, 13) - 1;
          in_valid <= 1'b0;
        end else if (src_pixels.size() > 0) begin
          in_data <= src_pixels.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every output transaction against the oldest prediction,
  // and drives out_ready with random stalls while idle_on, plus one long hold.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (bgra_expected.size() == 0) begin
          report_mismatch($sformatf("unexpected output %h", out_data));
        end else begin
          want = bgra_expected.pop_front();
          for (int b = 0; b < 4; b++) begin
            if (out_data[b*8 +: 8] !== want[b*8 +: 8])
              report_mismatch($sformatf("%s got %h expected %h", byte_name[b],
                                        out_data[b*8 +: 8], want[b*8 +: 8]));
          end
        end
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_ready <= 1'b0;
      end else if (hold_go && !hold_done) begin
        // long stall: the pipe fills and in_ready must drop
        hold_done = 1'b1;
        rx_stall = LONG_HOLD - 1;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        rx_stall = $urandom_range(1, 13) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset value of the format register: BGRA8 passthrough, high lane bits ignored.
    idle_on = 1'b1;
    push_px(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    push_px(16'hffff, 16'hffff, 16'hffff, 16'hffff);
    push_px(16'h5a12, 16'ha534, 16'h0f56, 16'hf078);

    // RGBA8 swizzle.
    wait_drained();
    write_format(FMT_RGBA8);
    push_px(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    push_px(16'hffff, 16'hffff, 16'hffff, 16'hffff);
    push_px(16'h5a12, 16'ha534, 16'h0f56, 16'hf078);

    // Code 3 has no meaning and falls back to passthrough.
    wait_drained();
    write_format(2'd3);
    push_px(16'h80ff, 16'h7f01, 16'hc3a5, 16'h3c5a);
    push_px(16'hffff, 16'h0000, 16'hffff, 16'h0000);

    // Half float: zeros, infinities, NaNs, one, denormal and normal edges.
    wait_drained();
    write_format(FMT_HALF);
    push_px(16'h0000, 16'h8000, 16'h7c00, 16'hfc00);   // +0, -0, +inf, -inf
    push_px(16'h7e00, 16'hfe01, 16'h7c01, 16'hffff);   // NaNs of either sign
    push_px(16'h3c00, 16'h3bff, 16'h7bff, 16'hbc00);   // 1.0, just below, max, -1
    push_px(16'h0001, 16'h03ff, 16'h0400, 16'h3800);   // denormals, min normal, 0.5
    push_px(16'h1c04, 16'h1c03, 16'h2008, 16'h3400);   // near rounding ties
    push_px(16'h4000, 16'h8001, 16'h5bff, 16'h0200);   // >1, tiny negative

    // Random phases; the first one carries the long receiver hold.
    run_phase(FMT_HALF, 200, 1'b1);
    hold_go = 1'b1;
    run_phase(FMT_BGRA8, 100, 1'b1);
    run_phase(FMT_RGBA8, 100, 1'b0);
    run_phase(FMT_HALF, 150, 1'b1);
    run_phase(2'd3, 50, 1'b1);
    run_phase(FMT_RGBA8, 100, 1'b1);
    run_phase(FMT_HALF, 150, 1'b0);   // no idling at the end

    wait_drained();
    repeat (10) @(posedge clk);
    if (errors == 0 && bgra_expected.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
